@@ rtl/core/mavlink2_frame_packer_top_assert.svh @@
// Assertion macros for the frame packer top level.
// Expects signals named clock and reset in the including scope.
`ifndef MAVLINK2_FRAME_PACKER_TOP_ASSERT_SVH
`define MAVLINK2_FRAME_PACKER_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MFP_ASSERT_NOW(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mfp_pkg.sv @@
// Shared types, constants and the CRC-16/X.25 byte update for the frame packer.
// No dependencies; every module of the block uses it by scoped names.
package mfp_pkg;

   localparam logic [7:0]  FRAME_MAGIC = 8'hFD;
   localparam logic [15:0] CRC_SEED    = 16'hFFFF;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSTEM_ID    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPONENT_ID = 8'd1;

   // Byte selector codes of the sequencer: header positions, then the special steps.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] HDR_MAGIC   = 4'd0;
   localparam logic [STEP_W-1:0] HDR_LEN     = 4'd1;
   localparam logic [STEP_W-1:0] HDR_FLAGS0  = 4'd2;
   localparam logic [STEP_W-1:0] HDR_FLAGS1  = 4'd3;
   localparam logic [STEP_W-1:0] HDR_SEQ     = 4'd4;
   localparam logic [STEP_W-1:0] HDR_SYSID   = 4'd5;
   localparam logic [STEP_W-1:0] HDR_COMPID  = 4'd6;
   localparam logic [STEP_W-1:0] HDR_MSG0    = 4'd7;
   localparam logic [STEP_W-1:0] HDR_MSG1    = 4'd8;
   localparam logic [STEP_W-1:0] HDR_MSG2    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd10;
   localparam logic [STEP_W-1:0] STEP_CRC_HI = 4'd11;
   localparam logic [STEP_W-1:0] STEP_DATA   = 4'd12;
   localparam logic [STEP_W-1:0] STEP_FIRST  = HDR_MAGIC;

   typedef struct packed {
      logic        frame_start;
      logic [23:0] message_id;
      logic [7:0]  payload_length;
      logic [7:0]  payload_byte;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       run_last;
   } out_byte_type;

   typedef struct packed {
      logic frame_open;
      logic mid_item;
   } seq_status_type;

   function automatic logic [15:0] crc_x25_update(input logic [7:0] data,
                                                  input logic [15:0] crc);
      logic [7:0] t;
      t = data ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

endpackage

@@ rtl/core/mfp_input_stage.sv @@
// Input register of the frame packer: holds one request until the sequencer is done.
// Depends on mfp_pkg for the item type.
module mfp_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfp_pkg::item_type req_item,
   input  logic              item_done,
   output logic              hold_valid,
   output mfp_pkg::item_type hold_item
);

   logic              hold_valid_ff;
   logic              hold_valid_in;
   mfp_pkg::item_type hold_ff;
   logic              load;

   // A new request may enter in the same cycle the held one finishes.
   assign req_stall     = hold_valid_ff & ~item_done;
   assign load          = req_valid & ~req_stall;
   assign hold_valid_in = load | (hold_valid_ff & ~item_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= req_item;
      end
   end

   assign hold_valid = hold_valid_ff;
   assign hold_item  = hold_ff;

endmodule

@@ rtl/core/mfp_sequencer.sv @@
// Byte sequencer: walks the header, payload and CRC bytes of the held item, one per cycle
// while out_ready is high, and keeps the frame state and running CRC. Depends on mfp_pkg.
module mfp_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold_valid,
   input  mfp_pkg::item_type       hold_item,
   input  logic                    out_ready,
   input  logic [7:0]              system_id,
   input  logic [7:0]              component_id,
   output logic                    item_done,
   output mfp_pkg::out_byte_type   emit,
   output mfp_pkg::seq_status_type status
);

   logic [mfp_pkg::STEP_W-1:0] step_ff, step_in;
   logic [15:0]                crc_ff, crc_in;
   logic [7:0]                 seq_ff, seq_in;
   logic [7:0]                 rem_ff, rem_in;
   logic                       open_ff, open_in;

   logic [mfp_pkg::STEP_W-1:0] cur;
   logic [mfp_pkg::STEP_W-1:0] nxt;
   logic                       live;
   logic                       emit_en;
   logic                       last;
   logic                       crc_upd;
   logic                       is_end;
   logic [7:0]                 tx;

   always_comb begin
      // A non-start item begins at the payload data step.
      cur = (!hold_item.frame_start && step_ff == mfp_pkg::STEP_FIRST) ?
            mfp_pkg::STEP_DATA : step_ff;
      live    = hold_item.frame_start | open_ff;
      emit_en = hold_valid & live & out_ready;
      tx      = 8'h00;
      last    = 1'b0;
      crc_upd = 1'b0;
      is_end  = 1'b0;
      nxt     = step_ff + mfp_pkg::STEP_W'(1);
      unique case (cur) inside
         mfp_pkg::HDR_MAGIC: begin
            tx = mfp_pkg::FRAME_MAGIC;
         end
         mfp_pkg::HDR_LEN: begin
            tx      = hold_item.payload_length;
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_FLAGS0, mfp_pkg::HDR_FLAGS1: begin
            tx      = 8'h00;
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_SEQ: begin
            tx      = seq_ff;
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_SYSID: begin
            tx      = system_id;
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_COMPID: begin
            tx      = component_id;
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_MSG0: begin
            tx      = hold_item.message_id[7:0];
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_MSG1: begin
            tx      = hold_item.message_id[15:8];
            crc_upd = 1'b1;
         end
         mfp_pkg::HDR_MSG2: begin
            tx      = hold_item.message_id[23:16];
            crc_upd = 1'b1;
            // A zero-length frame goes straight on to its CRC.
            if (hold_item.payload_length == 8'h00) begin
               nxt = mfp_pkg::STEP_CRC_LO;
            end else begin
               last = 1'b1;
            end
         end
         mfp_pkg::STEP_DATA: begin
            tx      = hold_item.payload_byte;
            crc_upd = 1'b1;
            if (rem_ff == 8'd1) begin
               nxt = mfp_pkg::STEP_CRC_LO;
            end else begin
               last = 1'b1;
            end
         end
         mfp_pkg::STEP_CRC_LO: begin
            tx  = crc_ff[7:0];
            nxt = mfp_pkg::STEP_CRC_HI;
         end
         mfp_pkg::STEP_CRC_HI: begin
            tx     = crc_ff[15:8];
            last   = 1'b1;
            is_end = 1'b1;
         end
         default: begin
            last = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      seq_in  = seq_ff;
      rem_in  = rem_ff;
      open_in = open_ff;
      if (emit_en) begin
         step_in = last ? mfp_pkg::STEP_FIRST : nxt;
         if (cur == mfp_pkg::HDR_MAGIC) begin
            crc_in = mfp_pkg::CRC_SEED;
         end else if (crc_upd) begin
            crc_in = mfp_pkg::crc_x25_update(tx, crc_ff);
         end
         if (cur == mfp_pkg::HDR_SEQ) begin
            seq_in = seq_ff + 8'd1;
         end
         if (cur == mfp_pkg::HDR_MSG2) begin
            rem_in  = hold_item.payload_length;
            open_in = (hold_item.payload_length != 8'h00);
         end else if (cur == mfp_pkg::STEP_DATA) begin
            // The frame stays open through its CRC bytes so the last payload item keeps going.
            rem_in  = rem_ff - 8'd1;
         end else if (cur == mfp_pkg::STEP_CRC_HI) begin
            rem_in  = 8'h00;
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mfp_pkg::STEP_FIRST;
         crc_ff  <= mfp_pkg::CRC_SEED;
         seq_ff  <= 8'h00;
         rem_ff  <= 8'h00;
         open_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         crc_ff  <= crc_in;
         seq_ff  <= seq_in;
         rem_ff  <= rem_in;
         open_ff <= open_in;
      end
   end

   // Items outside a frame finish at once with no bytes.
   assign item_done = hold_valid & (~live | (emit_en & last));

   assign emit.valid     = emit_en;
   assign emit.tx_byte   = tx;
   assign emit.frame_end = is_end;
   assign emit.run_last  = last;

   assign status.frame_open = open_ff;
   assign status.mid_item   = (step_ff != mfp_pkg::STEP_FIRST);

endmodule

@@ rtl/core/mfp_output_stage.sv @@
// Result register of the frame packer: holds one output byte until it is transferred.
// Depends on mfp_pkg for the output byte type.
module mfp_output_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  mfp_pkg::out_byte_type emit,
   output logic                  out_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_frame_end,
   output logic                  rsp_run_last
);

   logic                  valid_ff, valid_in;
   mfp_pkg::out_byte_type data_ff;

   assign out_ready = ~valid_ff | ~rsp_stall;
   assign valid_in  = emit.valid | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         data_ff <= emit;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_tx_byte   = data_ff.tx_byte;
   assign rsp_frame_end = data_ff.frame_end;
   assign rsp_run_last  = data_ff.run_last;

endmodule

@@ rtl/core/mavlink2_frame_packer_top.sv @@
// Top level of the MAVLink v2 style frame packer: configuration registers, input
// register, byte sequencer and result register. Depends on mfp_pkg and the three mfp_ modules.
//
// A start request produces the 10-byte header (12 bytes with the CRC for a zero-length
// frame), a payload request produces one byte (3 on the last payload byte, with the CRC),
// and a request outside a frame produces nothing. The result register moves one byte per
// cycle while rsp_stall is low, so a request holds the input until its last byte enters the
// result register; payload bytes therefore stream at one per cycle when the output does not
// stall, and an ignored request still passes through the input register. A request's first
// byte goes through the input register and then the result register to the result port. The
// configuration port is always ready; write it only while no frame bytes are pending.
module mavlink2_frame_packer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_frame_start,
   input  logic [23:0]                    req_message_id,
   input  logic [7:0]                     req_payload_length,
   input  logic [7:0]                     req_payload_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_tx_byte,
   output logic                           rsp_frame_end,
   output logic                           rsp_run_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_wdata
);

   logic [7:0] sysid_ff, sysid_in;
   logic [7:0] compid_ff, compid_in;

   mfp_pkg::item_type       req_item;
   mfp_pkg::item_type       hold_item;
   mfp_pkg::out_byte_type   emit;
   mfp_pkg::seq_status_type status;
   logic                    hold_valid;
   logic                    item_done;
   logic                    out_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      sysid_in  = sysid_ff;
      compid_in = compid_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mfp_pkg::CSR_SYSTEM_ID:    sysid_in  = csr_wdata;
            mfp_pkg::CSR_COMPONENT_ID: compid_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sysid_ff  <= 8'd1;
         compid_ff <= 8'd1;
      end else begin
         sysid_ff  <= sysid_in;
         compid_ff <= compid_in;
      end
   end

   assign req_item.frame_start    = req_frame_start;
   assign req_item.message_id     = req_message_id;
   assign req_item.payload_length = req_payload_length;
   assign req_item.payload_byte   = req_payload_byte;

   mfp_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .item_done  (item_done),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   mfp_sequencer u_seq (
      .clock        (clock),
      .reset        (reset),
      .hold_valid   (hold_valid),
      .hold_item    (hold_item),
      .out_ready    (out_ready),
      .system_id    (sysid_ff),
      .component_id (compid_ff),
      .item_done    (item_done),
      .emit         (emit),
      .status       (status)
   );

   mfp_output_stage u_output (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .out_ready     (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_last  (rsp_run_last)
   );

`include "mavlink2_frame_packer_top_assert.svh"

   // A stalled result must never be overwritten by the sequencer.
   `MFP_ASSERT_NOW(a_no_overwrite, !(rsp_valid && rsp_stall && emit.valid), "result overwritten while stalled")
   // Sending the last CRC byte closes the frame.
   `MFP_ASSERT_NEXT(a_end_closes, emit.valid && emit.frame_end, !status.frame_open, "frame still open after its CRC")
   // While the held request still has bytes to send, no new request may enter.
   `MFP_ASSERT_NOW(a_hold_busy, !(status.mid_item && !emit.valid) || req_stall, "input taken in the middle of a request")

endmodule

@@ tb/mavlink2_frame_packer_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for mavlink2_frame_packer_top: frame byte prediction with X.25 CRC,
// directed and random request streams under varied idle and stall patterns.
// Depends on mfp_pkg for the magic byte, CRC seed and register indexes.
module mavlink2_frame_packer_top_tb;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       run_last;
   } wire_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_frame_start;
   logic [23:0] req_message_id;
   logic [7:0]  req_payload_length;
   logic [7:0]  req_payload_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [mfp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [7:0]  csr_wdata;

   // Predictor copy of the packer state and its two header registers.
   logic [7:0]  sys_id;
   logic [7:0]  comp_id;
   logic [7:0]  seq_num;
   logic [7:0]  bytes_left;
   logic [15:0] run_crc;
   logic        frame_active;

   wire_byte_type  pending_bytes [$];
   wire_byte_type  want_byte;

   int sender_idle_pct;
   int rx_stall_pct;
   int hold_request;
   int hold_left;
   int fail_count;
   int requests_sent;
   int frames_started;
   int bytes_checked;

   mavlink2_frame_packer_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_start    (req_frame_start),
      .req_message_id     (req_message_id),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_run_last       (rsp_run_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] x25_next(input logic [7:0] data, input logic [15:0] crc);
      logic [7:0] mix;
      mix = data ^ crc[7:0];
      mix = mix ^ (mix << 4);
      return (crc >> 8) ^ ({8'h00, mix} << 8) ^ ({8'h00, mix} << 3) ^ ({8'h00, mix} >> 4);
   endfunction

   function automatic wire_byte_type wire_byte(input logic [7:0] value,
                                               input logic last_of_frame);
      wire_byte_type b;
      b.tx_byte   = value;
      b.frame_end = last_of_frame;
      b.run_last  = 1'b0;
      return b;
   endfunction

   // Works out the bytes one accepted request puts on the wire and queues them.
   function automatic void predict_frame_bytes(input logic start, input logic [23:0] msg,
                                               input logic [7:0] len, input logic [7:0] pb);
      logic [9:0][7:0] hdr;
      wire_byte_type   burst [$];
      logic            close_frame;
      close_frame = 1'b0;
      if (start) begin
         hdr = {msg[23:16], msg[15:8], msg[7:0], comp_id, sys_id, seq_num, 8'h00, 8'h00,
                len, mfp_pkg::FRAME_MAGIC};
         seq_num = seq_num + 8'd1;
         run_crc = mfp_pkg::CRC_SEED;
         for (int i = 0; i < 10; i++) begin
            // The magic byte is not covered by the checksum.
            if (i > 0) run_crc = x25_next(hdr[i], run_crc);
            burst.push_back(wire_byte(hdr[i], 1'b0));
         end
         if (len == 8'd0) begin
            close_frame = 1'b1;
         end else begin
            bytes_left   = len;
            frame_active = 1'b1;
         end
      end else if (frame_active) begin
         run_crc = x25_next(pb, run_crc);
         burst.push_back(wire_byte(pb, 1'b0));
         bytes_left = bytes_left - 8'd1;
         if (bytes_left == 8'd0) close_frame = 1'b1;
      end
      if (close_frame) begin
         burst.push_back(wire_byte(run_crc[7:0], 1'b0));
         burst.push_back(wire_byte(run_crc[15:8], 1'b1));
         frame_active = 1'b0;
         bytes_left   = 8'd0;
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
      foreach (burst[i]) pending_bytes.push_back(burst[i]);
   endfunction

   // Offers one request, holds it until the transfer, then predicts its bytes.
   task automatic send_request(input logic start, input logic [23:0] msg,
                               input logic [7:0] len, input logic [7:0] pb);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_frame_start    <= start;
      req_message_id     <= msg;
      req_payload_length <= len;
      req_payload_byte   <= pb;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_frame_bytes(start, msg, len, pb);
      requests_sent++;
      if (start) frames_started++;
   endtask

   // Stops offering requests and waits until every predicted byte has been seen.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() > 0) @(posedge clock);
      // An ignored request can still sit in the input register.
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mfp_pkg::CSR_IDX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == mfp_pkg::CSR_SYSTEM_ID) sys_id = value;
      else if (idx == mfp_pkg::CSR_COMPONENT_ID) comp_id = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      rx_stall_pct    = receiver_pct;
   endtask

   task automatic test_directed_frames();
      // Nothing is open yet, so this request must vanish.
      send_request(1'b0, 24'hFFFFFF, 8'hFF, 8'hFF);
      send_request(1'b1, 24'h000000, 8'h00, 8'h00);
      send_request(1'b1, 24'hFFFFFF, 8'h00, 8'hFF);
      send_request(1'b1, 24'h123456, 8'h01, 8'hFF);
      send_request(1'b0, 24'h000000, 8'h00, 8'hFF);
      send_request(1'b1, 24'h00A5C3, 8'h03, 8'h5A);
      send_request(1'b0, 24'hFFFFFF, 8'hFF, 8'h00);
      send_request(1'b0, 24'h000000, 8'h00, 8'hFF);
      send_request(1'b0, 24'h555555, 8'h55, 8'hA5);
      // A long frame cut short by a new start, which then completes.
      send_request(1'b1, 24'hFFFFFF, 8'hFF, 8'h00);
      send_request(1'b0, 24'h000000, 8'h00, 8'h81);
      send_request(1'b0, 24'h000000, 8'h00, 8'h7E);
      send_request(1'b1, 24'h800001, 8'h02, 8'h00);
      send_request(1'b0, 24'h000000, 8'h00, 8'h01);
      send_request(1'b0, 24'h000000, 8'h00, 8'h80);
      send_request(1'b0, 24'hAAAAAA, 8'hAA, 8'hAA);
      wait_drained();
   endtask

   task automatic test_config_extremes();
      write_csr(mfp_pkg::CSR_SYSTEM_ID, 8'h00);
      write_csr(mfp_pkg::CSR_COMPONENT_ID, 8'hFF);
      send_request(1'b1, 24'h0F0F0F, 8'h00, 8'h00);
      send_request(1'b1, 24'hF0F0F0, 8'h01, 8'h00);
      send_request(1'b0, 24'h000000, 8'h00, 8'hC3);
      wait_drained();
      write_csr(mfp_pkg::CSR_SYSTEM_ID, 8'hFF);
      write_csr(mfp_pkg::CSR_COMPONENT_ID, 8'h00);
      send_request(1'b1, 24'h3C3C3C, 8'h00, 8'h00);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      hold_request = HOLD_CYCLES;
      send_request(1'b1, 24'($urandom_range(0, 24'hFFFFFF)), 8'd30, 8'h00);
      repeat (30) send_request(1'b0, 24'h000000, 8'h00, 8'($urandom_range(0, 255)));
      // The sender pauses here until the whole backlog has come out.
      wait_drained();
   endtask

   task automatic test_random_traffic(input int item_target);
      int sent;
      int len;
      int body;
      bit counts;
      sent = 0;
      while (sent < item_target) begin
         if ($urandom_range(0, 99) < 12) begin
            // Arbitrary request; it only matters when it starts or extends a frame.
            counts = 1'b0;
            if ($urandom_range(0, 1) == 1) begin
               counts = 1'b1;
               send_request(1'b1, 24'($urandom_range(0, 24'hFFFFFF)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
               counts = frame_active;
               send_request(1'b0, 24'($urandom_range(0, 24'hFFFFFF)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            if (counts) sent++;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 8);
            body = len;
            // Long frames and a few short ones are cut off by the next start.
            if (len > 12 || $urandom_range(0, 9) == 0)
               body = $urandom_range(0, (len > 6) ? 6 : len);
            send_request(1'b1, 24'($urandom_range(0, 24'hFFFFFF)), 8'(len),
                         8'($urandom_range(0, 255)));
            repeat (body) send_request(1'b0, 24'($urandom_range(0, 24'hFFFFFF)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
            sent += 1 + body;
         end
      end
      wait_drained();
   endtask

   // Receiver side: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $error("Unexpected transfer: tx_byte %02h frame_end %0b run_last %0b",
                   rsp_tx_byte, rsp_frame_end, rsp_run_last);
            fail_count++;
         end else begin
            want_byte = pending_bytes.pop_front();
            bytes_checked++;
            if (rsp_tx_byte !== want_byte.tx_byte) begin
               $error("tx_byte mismatch: expected %02h, actual %02h",
                      want_byte.tx_byte, rsp_tx_byte);
               fail_count++;
            end
            if (rsp_frame_end !== want_byte.frame_end) begin
               $error("frame_end mismatch: expected %0b, actual %0b",
                      want_byte.frame_end, rsp_frame_end);
               fail_count++;
            end
            if (rsp_run_last !== want_byte.run_last) begin
               $error("run_last mismatch: expected %0b, actual %0b",
                      want_byte.run_last, rsp_run_last);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_frame_start    = 1'b0;
      req_message_id     = 24'h000000;
      req_payload_length = 8'h00;
      req_payload_byte   = 8'h00;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = mfp_pkg::CSR_SYSTEM_ID;
      csr_wdata          = 8'h00;
      sys_id             = 8'd1;
      comp_id            = 8'd1;
      seq_num            = 8'd0;
      bytes_left         = 8'd0;
      run_crc            = mfp_pkg::CRC_SEED;
      frame_active       = 1'b0;
      sender_idle_pct    = 0;
      rx_stall_pct       = 0;
      hold_request       = 0;
      hold_left          = 0;
      fail_count         = 0;
      requests_sent      = 0;
      frames_started     = 0;
      bytes_checked      = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_config_extremes();
      test_output_backpressure();

      set_idling(0, 0);
      write_csr(mfp_pkg::CSR_SYSTEM_ID, 8'($urandom_range(0, 255)));
      write_csr(mfp_pkg::CSR_COMPONENT_ID, 8'($urandom_range(0, 255)));
      test_random_traffic(12);
      set_idling(54, 0);
      write_csr(mfp_pkg::CSR_SYSTEM_ID, 8'($urandom_range(0, 255)));
      test_random_traffic(12);
      set_idling(0, 54);
      write_csr(mfp_pkg::CSR_COMPONENT_ID, 8'($urandom_range(0, 255)));
      test_random_traffic(12);
      set_idling(19, 19);
      write_csr(mfp_pkg::CSR_SYSTEM_ID, 8'($urandom_range(0, 255)));
      write_csr(mfp_pkg::CSR_COMPONENT_ID, 8'($urandom_range(0, 255)));
      test_random_traffic(12);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d request transfers, %0d frames and %0d checked output bytes,",
               requests_sent, frames_started, bytes_checked);
      $display("including zero-length and abandoned frames, a long output hold-off and four idle/stall mixes.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mfp_pkg.sv
rtl/core/mfp_input_stage.sv
rtl/core/mfp_sequencer.sv
rtl/core/mfp_output_stage.sv
rtl/core/mavlink2_frame_packer_top.sv
tb/mavlink2_frame_packer_top_tb.sv
